[src/ote_pkg.sv]
// ----------------------------------------------------------------------------
// ote_pkg
// Shared types and fixed constants of the oriented triangle emitter.
// ----------------------------------------------------------------------------
package ote_pkg;

  // item kinds
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FACE   = 1'b1;

  // fixed field widths
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned GRAD_W      = 16;
  localparam int unsigned THR_W       = 63;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned COORD_MAX_W = 24;

  // squared norm and its saturation limit for one component
  localparam int unsigned NORM_W = 64;
  localparam int unsigned HALF_W = NORM_W / 2;

  // index reduction by reciprocal multiply
  localparam int unsigned RECIP_SHIFT = 24;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic load_quot;
    logic load_addr;
    logic mem_we;
    logic rd_a;
    logic rd_b;
    logic rd_c;
    logic grab_base;
    logic grab_u;
    logic grab_v;
    logic load_prod;
    logic load_norm;
    logic load_sq;
    logic load_sum;
    logic finish;
  } ote_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_face;
  } ote_sts_t;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_RED1   = 13'b0000000000010,
    ST_RED2   = 13'b0000000000100,
    ST_WRITE  = 13'b0000000001000,
    ST_RD_A   = 13'b0000000010000,
    ST_RD_B   = 13'b0000000100000,
    ST_RD_C   = 13'b0000001000000,
    ST_DIFF   = 13'b0000010000000,
    ST_CROSS  = 13'b0000100000000,
    ST_NORMAL = 13'b0001000000000,
    ST_SQUARE = 13'b0010000000000,
    ST_SUM    = 13'b0100000000000,
    ST_FINAL  = 13'b1000000000000
  } ote_state_e;

endpackage

[src/ote_ram.sv]
// ----------------------------------------------------------------------------
// ote_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ote_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/ote_ctrl.sv]
// ----------------------------------------------------------------------------
// ote_ctrl
// Sequencer: index reduction, then a vertex write, or three reads followed by the
// multiply chain and the final decision, one step per state.
// ----------------------------------------------------------------------------
module ote_ctrl import ote_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  ote_sts_t sts_i,
  output logic     busy_o,
  output ote_cmd_t cmd_o
);

  ote_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_RED1;
        end
      end
      ST_RED1: begin
        cmd_o.load_quot = 1'b1;
        state_d         = ST_RED2;
      end
      ST_RED2: begin
        cmd_o.load_addr = 1'b1;
        state_d         = sts_i.is_face ? ST_RD_A : ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.mem_we = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_RD_A: begin
        cmd_o.rd_a = 1'b1;
        state_d    = ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.rd_b      = 1'b1;
        cmd_o.grab_base = 1'b1;
        state_d         = ST_RD_C;
      end
      ST_RD_C: begin
        cmd_o.rd_c   = 1'b1;
        cmd_o.grab_u = 1'b1;
        state_d      = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.grab_v = 1'b1;
        state_d      = ST_CROSS;
      end
      ST_CROSS: begin
        cmd_o.load_prod = 1'b1;
        state_d         = ST_NORMAL;
      end
      ST_NORMAL: begin
        cmd_o.load_norm = 1'b1;
        state_d         = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.load_sq = 1'b1;
        state_d       = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.load_sum = 1'b1;
        state_d        = ST_FINAL;
      end
      ST_FINAL: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[src/ote_dp.sv]
// ----------------------------------------------------------------------------
// ote_dp
// Datapath: item registers, index reduction, vertex store, edge vectors,
// cross product, saturated squared norm, exact dot product sign, counter.
// ----------------------------------------------------------------------------
module ote_dp import ote_pkg::*; #(
  parameter int unsigned VERTEX_DEPTH = 4096,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ote_cmd_t                 cmd_i,
  output ote_sts_t                 sts_o,
  input  logic                     thr_we_i,
  input  logic [THR_W-1:0]         thr_i,
  input  logic                     kind_i,
  input  logic [IDX_W-1:0]         vertex_slot_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [POS_W-1:0]  pos_z_i,
  input  logic [IDX_W-1:0]         corner_a_i,
  input  logic [IDX_W-1:0]         corner_b_i,
  input  logic [IDX_W-1:0]         corner_c_i,
  input  logic signed [GRAD_W-1:0] grad_x_i,
  input  logic signed [GRAD_W-1:0] grad_y_i,
  input  logic signed [GRAD_W-1:0] grad_z_i,
  output logic                     done_o,
  output logic                     emitted_o,
  output logic [IDX_W-1:0]         out_first_o,
  output logic [IDX_W-1:0]         out_second_o,
  output logic [IDX_W-1:0]         out_third_o,
  output logic [CNT_W-1:0]         rejected_total_o
);

  localparam int unsigned AW  = $clog2(VERTEX_DEPTH);
  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned EW  = 3 * CW;
  localparam int unsigned DW  = CW + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned NW  = PW + 1;
  localparam int unsigned DPW = NW + GRAD_W;
  localparam int unsigned SW  = DPW + 2;
  localparam int unsigned QW  = IDX_W + RECIP_SHIFT;
  localparam int unsigned RW  = AW + 1 + IDX_W;
  localparam logic [RECIP_SHIFT-1:0] RECIP =
    RECIP_SHIFT'((1 << RECIP_SHIFT) / VERTEX_DEPTH);
  localparam logic [RW-1:0] DEPTH_R = RW'(VERTEX_DEPTH);

  // item registers
  logic                     kind_q;
  logic [IDX_W-1:0]         idx_q   [3];
  logic signed [GRAD_W-1:0] g_q     [3];
  logic [EW-1:0]            wdata_q;

  // index reduction
  logic [IDX_W-1:0] q_q    [3];
  logic [AW-1:0]    addr_q [3];
  logic [QW-1:0]    qprod  [3];
  logic [IDX_W+RW-1:0] qd  [3];
  logic [IDX_W-1:0] r_est  [3];
  logic [RW-1:0]    r_ext  [3];
  logic [RW-1:0]    r_fix  [3];

  // store access
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic signed [CW-1:0] rd_crd [3];

  // arithmetic chain
  logic signed [CW-1:0]  base_q [3];
  logic signed [DW-1:0]  u_q    [3];
  logic signed [DW-1:0]  v_q    [3];
  logic signed [PW-1:0]  prod_q [6];
  logic signed [NW-1:0]  n_q    [3];
  logic [NW-1:0]         mag    [3];
  logic [NORM_W-1:0]     mag64  [3];
  logic [NORM_W-1:0]     sq_d   [3];
  logic [NORM_W-1:0]     sq_q   [3];
  logic signed [DPW-1:0] dot_q  [3];
  logic [NORM_W:0]       psum;
  logic [NORM_W-1:0]     part_sq_q;
  logic signed [SW-1:0]  part_dot_q;
  logic [NORM_W:0]       fsum;
  logic [NORM_W-1:0]     norm2;
  logic signed [SW-1:0]  dot_tot;
  logic                  dup;
  logic                  reject;

  // config, counter and result registers
  logic [THR_W-1:0] thr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic             emitted_q;
  logic [IDX_W-1:0] first_q;
  logic [IDX_W-1:0] second_q;
  logic [IDX_W-1:0] third_q;

  logic [COORD_MAX_W-1:0] px_ext;
  logic [COORD_MAX_W-1:0] py_ext;
  logic [COORD_MAX_W-1:0] pz_ext;

  // low coordinate bits of the raw field
  assign px_ext = COORD_MAX_W'($unsigned(pos_x_i));
  assign py_ext = COORD_MAX_W'($unsigned(pos_y_i));
  assign pz_ext = COORD_MAX_W'($unsigned(pos_z_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      idx_q[0] <= (kind_i == KIND_FACE) ? corner_a_i : vertex_slot_i;
      idx_q[1] <= corner_b_i;
      idx_q[2] <= corner_c_i;
      g_q[0]   <= grad_x_i;
      g_q[1]   <= grad_y_i;
      g_q[2]   <= grad_z_i;
      wdata_q  <= {pz_ext[CW-1:0], py_ext[CW-1:0], px_ext[CW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_VERTEX;
    end else if (cmd_i.load_item) begin
      kind_q <= kind_i;
    end
  end

  assign sts_o.is_face = (kind_q == KIND_FACE);

  // quotient estimate is exact or one short, one correction step
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qprod[l] = idx_q[l] * RECIP;
      qd[l]    = q_q[l] * DEPTH_R;
      r_est[l] = idx_q[l] - qd[l][IDX_W-1:0];
      r_ext[l] = RW'(r_est[l]);
      r_fix[l] = (r_ext[l] >= DEPTH_R) ? (r_ext[l] - DEPTH_R) : r_ext[l];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      if (cmd_i.load_quot) begin
        q_q[l] <= qprod[l][QW-1:RECIP_SHIFT];
      end
      if (cmd_i.load_addr) begin
        addr_q[l] <= r_fix[l][AW-1:0];
      end
    end
  end

  assign rd_en = cmd_i.rd_a | cmd_i.rd_b | cmd_i.rd_c;
  assign raddr = cmd_i.rd_b ? addr_q[1] : (cmd_i.rd_c ? addr_q[2] : addr_q[0]);

  ote_ram #(
    .WIDTH (EW),
    .DEPTH (VERTEX_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .waddr_i (addr_q[0]),
    .wdata_i (wdata_q),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_crd[k] = $signed(rdata[k*CW +: CW]);
    end
  end

  // edge vectors, cross product terms, normal
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.grab_base) begin
        base_q[k] <= rd_crd[k];
      end
      if (cmd_i.grab_u) begin
        u_q[k] <= DW'(rd_crd[k]) - DW'(base_q[k]);
      end
      if (cmd_i.grab_v) begin
        v_q[k] <= DW'(rd_crd[k]) - DW'(base_q[k]);
      end
      if (cmd_i.load_norm) begin
        n_q[k] <= NW'(prod_q[2*k]) - NW'(prod_q[2*k+1]);
      end
      if (cmd_i.load_sq) begin
        sq_q[k]  <= sq_d[k];
        dot_q[k] <= DPW'(n_q[k]) * DPW'(g_q[k]);
      end
    end
    if (cmd_i.load_prod) begin
      prod_q[0] <= PW'(u_q[1]) * PW'(v_q[2]);
      prod_q[1] <= PW'(u_q[2]) * PW'(v_q[1]);
      prod_q[2] <= PW'(u_q[2]) * PW'(v_q[0]);
      prod_q[3] <= PW'(u_q[0]) * PW'(v_q[2]);
      prod_q[4] <= PW'(u_q[0]) * PW'(v_q[1]);
      prod_q[5] <= PW'(u_q[1]) * PW'(v_q[0]);
    end
    if (cmd_i.load_sum) begin
      part_sq_q  <= psum[NORM_W] ? '1 : psum[NORM_W-1:0];
      part_dot_q <= SW'(dot_q[0]) + SW'(dot_q[1]);
    end
  end

  // component square saturates once the magnitude reaches 2^32
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]   = n_q[k][NW-1] ? $unsigned(-n_q[k]) : $unsigned(n_q[k]);
      mag64[k] = NORM_W'(mag[k]);
      if (|mag64[k][NORM_W-1:HALF_W]) begin
        sq_d[k] = '1;
      end else begin
        sq_d[k] = mag64[k][HALF_W-1:0] * mag64[k][HALF_W-1:0];
      end
    end
  end

  assign psum    = {1'b0, sq_q[0]} + {1'b0, sq_q[1]};
  assign fsum    = {1'b0, part_sq_q} + {1'b0, sq_q[2]};
  assign norm2   = fsum[NORM_W] ? '1 : fsum[NORM_W-1:0];
  assign dot_tot = part_dot_q + SW'(dot_q[2]);
  assign dup     = (idx_q[0] == idx_q[1]) || (idx_q[1] == idx_q[2]) ||
                   (idx_q[2] == idx_q[0]);
  assign reject  = dup || (norm2 <= {1'b0, thr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (thr_we_i) begin
      thr_q <= thr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.finish && reject && (cnt_q != '1)) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (reject) begin
        emitted_q <= 1'b0;
        first_q   <= '0;
        second_q  <= '0;
        third_q   <= '0;
      end else begin
        // swap on a strictly negative dot product
        emitted_q <= 1'b1;
        first_q   <= idx_q[0];
        second_q  <= dot_tot[SW-1] ? idx_q[2] : idx_q[1];
        third_q   <= dot_tot[SW-1] ? idx_q[1] : idx_q[2];
      end
    end
  end

  assign done_o           = done_q;
  assign emitted_o        = emitted_q;
  assign out_first_o      = first_q;
  assign out_second_o     = second_q;
  assign out_third_o      = third_q;
  assign rejected_total_o = cnt_q;

endmodule

[src/oriented_triangle_emitter_core.sv]
// ----------------------------------------------------------------------------
// oriented_triangle_emitter_core
// Vertex store plus face check: rejects degenerate faces, orients the rest
// against a gradient.
//
//   channel   direction  handshake                   payload
//   item      in         start_i / busy_o            kind, slot, pos, corners,
//                                                    grad
//   result    out        done_o (one-cycle strobe)   emitted, out indices,
//                                                    rejected_total
//   config    in         area_threshold_we_i         area_threshold_i
//
// A vertex write keeps busy_o high through the reduction and write states, a face
// through the reduction, the reads and the multiply chain; the face result is on
// done_o in the cycle right after the last busy one, and the next item can be taken
// in that same cycle. The face sequence comes from
// the two-step index reduction, three reads through the single store read
// port and the multiply chain (cross product, squares and dot product, sums).
// Reset clears the controller, threshold and counter; the store has no
// clearing pass and holds nothing until written. Results cannot be stalled.
// ----------------------------------------------------------------------------
module oriented_triangle_emitter_core import ote_pkg::*; #(
  parameter int unsigned VERTEX_DEPTH = 4096,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     area_threshold_we_i,
  input  logic [THR_W-1:0]         area_threshold_i,
  input  logic                     kind_i,
  input  logic [IDX_W-1:0]         vertex_slot_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [POS_W-1:0]  pos_z_i,
  input  logic [IDX_W-1:0]         corner_a_i,
  input  logic [IDX_W-1:0]         corner_b_i,
  input  logic [IDX_W-1:0]         corner_c_i,
  input  logic signed [GRAD_W-1:0] grad_x_i,
  input  logic signed [GRAD_W-1:0] grad_y_i,
  input  logic signed [GRAD_W-1:0] grad_z_i,
  output logic                     done_o,
  output logic                     emitted_o,
  output logic [IDX_W-1:0]         out_first_o,
  output logic [IDX_W-1:0]         out_second_o,
  output logic [IDX_W-1:0]         out_third_o,
  output logic [CNT_W-1:0]         rejected_total_o
);

  ote_cmd_t cmd;
  ote_sts_t sts;

  ote_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  ote_dp #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .thr_we_i         (area_threshold_we_i),
    .thr_i            (area_threshold_i),
    .kind_i           (kind_i),
    .vertex_slot_i    (vertex_slot_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .corner_a_i       (corner_a_i),
    .corner_b_i       (corner_b_i),
    .corner_c_i       (corner_c_i),
    .grad_x_i         (grad_x_i),
    .grad_y_i         (grad_y_i),
    .grad_z_i         (grad_z_i),
    .done_o           (done_o),
    .emitted_o        (emitted_o),
    .out_first_o      (out_first_o),
    .out_second_o     (out_second_o),
    .out_third_o      (out_third_o),
    .rejected_total_o (rejected_total_o)
  );

  // a result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without preceding work");

  // a transfer always starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not start work");

  // an emitted face never repeats an index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && emitted_o) |-> ((out_first_o != out_second_o) &&
                               (out_second_o != out_third_o) &&
                               (out_first_o != out_third_o)))
    else $error("emitted face with repeated index");

  // the rejection count only changes at a result and never drops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |=> (rejected_total_o == $past(rejected_total_o)) || done_o)
    else $error("rejection count moved outside a result");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the oriented triangle emitter core. Vertex writes
// fill a local copy of the store. Each face transfer is predicted (degenerate
// rejection, saturating reject count, orientation by the sign of the normal
// dotted with the gradient) and checked against the done_o strobe, in order.
// ----------------------------------------------------------------------------
module tb;
  import ote_pkg::*;

  localparam int unsigned SLOT_COUNT     = 4096;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam int unsigned BATCH_ITEMS    = 100;

  typedef struct {
    logic                     kind;
    logic [IDX_W-1:0]         slot;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [IDX_W-1:0]         corner_a;
    logic [IDX_W-1:0]         corner_b;
    logic [IDX_W-1:0]         corner_c;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    bit                       wait_drain;
  } mesh_item_t;

  typedef struct {
    logic             emitted;
    logic [IDX_W-1:0] idx_first;
    logic [IDX_W-1:0] idx_second;
    logic [IDX_W-1:0] idx_third;
    logic [CNT_W-1:0] reject_total;
  } face_result_t;

  logic                     clk_i               = 1'b0;
  logic                     rst_ni              = 1'b0;
  logic                     start_i             = 1'b0;
  logic                     area_threshold_we_i = 1'b0;
  logic [THR_W-1:0]         area_threshold_i    = '0;
  logic                     kind_i              = 1'b0;
  logic [IDX_W-1:0]         vertex_slot_i       = '0;
  logic signed [POS_W-1:0]  pos_x_i             = '0;
  logic signed [POS_W-1:0]  pos_y_i             = '0;
  logic signed [POS_W-1:0]  pos_z_i             = '0;
  logic [IDX_W-1:0]         corner_a_i          = '0;
  logic [IDX_W-1:0]         corner_b_i          = '0;
  logic [IDX_W-1:0]         corner_c_i          = '0;
  logic signed [GRAD_W-1:0] grad_x_i            = '0;
  logic signed [GRAD_W-1:0] grad_y_i            = '0;
  logic signed [GRAD_W-1:0] grad_z_i            = '0;
  logic                     busy_o;
  logic                     done_o;
  logic                     emitted_o;
  logic [IDX_W-1:0]         out_first_o;
  logic [IDX_W-1:0]         out_second_o;
  logic [IDX_W-1:0]         out_third_o;
  logic [CNT_W-1:0]         rejected_total_o;

  // local copy of the block state
  logic signed [POS_W-1:0] store_x [SLOT_COUNT];
  logic signed [POS_W-1:0] store_y [SLOT_COUNT];
  logic signed [POS_W-1:0] store_z [SLOT_COUNT];
  logic [THR_W-1:0]        threshold_now = '0;
  logic [CNT_W-1:0]        reject_count  = '0;

  mesh_item_t   item_q[$];
  mesh_item_t   cur_item;
  face_result_t face_expect_q[$];

  // slots written so far, so faces only read written vertices
  bit               slot_used [SLOT_COUNT];
  logic [IDX_W-1:0] used_slots[$];

  int          items_queued    = 0;
  int          items_taken     = 0;
  int          sender_idle_pct = 0;
  int          mismatch_count  = 0;
  int unsigned stall_cycles    = 0;

  oriented_triangle_emitter_core u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .area_threshold_we_i (area_threshold_we_i),
    .area_threshold_i    (area_threshold_i),
    .kind_i              (kind_i),
    .vertex_slot_i       (vertex_slot_i),
    .pos_x_i             (pos_x_i),
    .pos_y_i             (pos_y_i),
    .pos_z_i             (pos_z_i),
    .corner_a_i          (corner_a_i),
    .corner_b_i          (corner_b_i),
    .corner_c_i          (corner_c_i),
    .grad_x_i            (grad_x_i),
    .grad_y_i            (grad_y_i),
    .grad_z_i            (grad_z_i),
    .done_o              (done_o),
    .emitted_o           (emitted_o),
    .out_first_o         (out_first_o),
    .out_second_o        (out_second_o),
    .out_third_o         (out_third_o),
    .rejected_total_o    (rejected_total_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  function automatic logic [63:0] square_clip(longint v);
    logic [63:0] mag;
    mag = (v < 0) ? -v : v;
    if (mag[63:32] != '0) return '1;
    return mag * mag;
  endfunction

  function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // applies one transferred item to the local state, queues the face outcome
  function automatic void predict_item(mesh_item_t it);
    longint       ux, uy, uz, vx, vy, vz, nx, ny, nz, dot;
    logic [63:0]  norm2;
    face_result_t r;
    if (it.kind == KIND_VERTEX) begin
      store_x[it.slot] = it.pos_x;
      store_y[it.slot] = it.pos_y;
      store_z[it.slot] = it.pos_z;
      return;
    end
    ux = longint'(store_x[it.corner_b]) - longint'(store_x[it.corner_a]);
    uy = longint'(store_y[it.corner_b]) - longint'(store_y[it.corner_a]);
    uz = longint'(store_z[it.corner_b]) - longint'(store_z[it.corner_a]);
    vx = longint'(store_x[it.corner_c]) - longint'(store_x[it.corner_a]);
    vy = longint'(store_y[it.corner_c]) - longint'(store_y[it.corner_a]);
    vz = longint'(store_z[it.corner_c]) - longint'(store_z[it.corner_a]);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    norm2 = add_clip(add_clip(square_clip(nx), square_clip(ny)), square_clip(nz));
    if (it.corner_a == it.corner_b || it.corner_b == it.corner_c ||
        it.corner_c == it.corner_a || norm2 <= {1'b0, threshold_now}) begin
      if (reject_count != '1) reject_count++;
      r.emitted    = 1'b0;
      r.idx_first  = '0;
      r.idx_second = '0;
      r.idx_third  = '0;
    end else begin
      dot = nx * longint'(it.grad_x) + ny * longint'(it.grad_y) +
            nz * longint'(it.grad_z);
      r.emitted    = 1'b1;
      r.idx_first  = it.corner_a;
      r.idx_second = (dot < 0) ? it.corner_c : it.corner_b;
      r.idx_third  = (dot < 0) ? it.corner_b : it.corner_c;
    end
    r.reject_total = reject_count;
    face_expect_q.insert(face_expect_q.size(), r);
  endfunction

  function automatic void queue_vertex(logic [IDX_W-1:0] slot, int x, int y, int z);
    mesh_item_t it;
    it.kind       = KIND_VERTEX;
    it.slot       = slot;
    it.pos_x      = x[POS_W-1:0];
    it.pos_y      = y[POS_W-1:0];
    it.pos_z      = z[POS_W-1:0];
    it.corner_a   = IDX_W'($urandom);
    it.corner_b   = IDX_W'($urandom);
    it.corner_c   = IDX_W'($urandom);
    it.grad_x     = GRAD_W'($urandom);
    it.grad_y     = GRAD_W'($urandom);
    it.grad_z     = GRAD_W'($urandom);
    it.wait_drain = 1'b0;
    if (!slot_used[slot]) begin
      slot_used[slot] = 1'b1;
      used_slots.insert(used_slots.size(), slot);
    end
    items_queued++;
    item_q.insert(item_q.size(), it);
  endfunction

  function automatic void queue_face(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                     logic [IDX_W-1:0] c, int gx, int gy, int gz,
                                     bit drain);
    mesh_item_t it;
    it.kind       = KIND_FACE;
    it.slot       = IDX_W'($urandom);
    it.pos_x      = POS_W'($urandom);
    it.pos_y      = POS_W'($urandom);
    it.pos_z      = POS_W'($urandom);
    it.corner_a   = a;
    it.corner_b   = b;
    it.corner_c   = c;
    it.grad_x     = gx[GRAD_W-1:0];
    it.grad_y     = gy[GRAD_W-1:0];
    it.grad_z     = gz[GRAD_W-1:0];
    it.wait_drain = drain;
    items_queued++;
    item_q.insert(item_q.size(), it);
  endfunction

  function automatic int rand_coord();
    int mode;
    mode = $urandom_range(9);
    if (mode < 4) return int'($urandom_range(600)) - 300;
    if (mode < 8) return int'($urandom_range(65535)) - 32768;
    return $urandom_range(1) ? 32767 : -32768;
  endfunction

  function automatic int rand_grad();
    if ($urandom_range(19) == 0) return 0;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic logic [IDX_W-1:0] pick_used();
    return used_slots[$urandom_range(used_slots.size() - 1)];
  endfunction

  // mostly faces over written slots between vertex writes, plus
  // collinear triples and faces with repeated corners
  function automatic void queue_mesh_batch(int count);
    int               made;
    int               pick;
    int               ax, ay, az, dx, dy, dz;
    logic [IDX_W-1:0] sa, sb, sc;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 22 || used_slots.size() < 3) begin
        queue_vertex(IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord());
        made++;
      end else if (pick < 30) begin
        sa = IDX_W'($urandom);
        sb = sa + 1'b1;
        sc = sa + 2'd2;
        ax = int'($urandom_range(16000)) - 8000;
        ay = int'($urandom_range(16000)) - 8000;
        az = int'($urandom_range(16000)) - 8000;
        dx = int'($urandom_range(8000)) - 4000;
        dy = int'($urandom_range(8000)) - 4000;
        dz = int'($urandom_range(8000)) - 4000;
        queue_vertex(sa, ax, ay, az);
        queue_vertex(sb, ax + dx, ay + dy, az + dz);
        queue_vertex(sc, ax + 2 * dx, ay + 2 * dy, az + 2 * dz);
        queue_face(sb, sa, sc, rand_grad(), rand_grad(), rand_grad(), 1'b0);
        made += 4;
      end else if (pick < 38) begin
        sa = pick_used();
        sb = pick_used();
        case ($urandom_range(2))
          0: begin
            queue_face(sa, sa, sb, rand_grad(), rand_grad(), rand_grad(), 1'b0);
          end
          1: begin
            queue_face(sb, sa, sa, rand_grad(), rand_grad(), rand_grad(), 1'b0);
          end
          default: begin
            queue_face(sa, sb, sa, rand_grad(), rand_grad(), rand_grad(), 1'b0);
          end
        endcase
        made++;
      end else begin
        queue_face(pick_used(), pick_used(), pick_used(), rand_grad(), rand_grad(),
                   rand_grad(), $urandom_range(99) < 3);
        made++;
      end
    end
  endfunction

  task automatic wait_idle();
    while (items_taken != items_queued || face_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] value);
    wait_idle();
    area_threshold_we_i <= 1'b1;
    area_threshold_i    <= value;
    threshold_now = value;
    @(posedge clk_i);
    area_threshold_we_i <= 1'b0;
  endtask

  // driver: one transfer when start_i is high and busy_o low
  always @(posedge clk_i) begin
    mesh_item_t nxt;
    logic       taken;
    if (rst_ni) begin
      taken = start_i && !busy_o;
      if (taken) begin
        items_taken++;
        predict_item(cur_item);
      end
      if (taken || !start_i) begin
        if (item_q.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
            !(item_q[0].wait_drain && face_expect_q.size() != 0)) begin
          nxt = item_q.pop_front();
          cur_item      <= nxt;
          start_i       <= 1'b1;
          kind_i        <= nxt.kind;
          vertex_slot_i <= nxt.slot;
          pos_x_i       <= nxt.pos_x;
          pos_y_i       <= nxt.pos_y;
          pos_z_i       <= nxt.pos_z;
          corner_a_i    <= nxt.corner_a;
          corner_b_i    <= nxt.corner_b;
          corner_c_i    <= nxt.corner_c;
          grad_x_i      <= nxt.grad_x;
          grad_y_i      <= nxt.grad_y;
          grad_z_i      <= nxt.grad_z;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every done_o strobe is checked against the oldest pending face
  always @(posedge clk_i) begin
    face_result_t want;
    if (rst_ni && done_o) begin
      if (face_expect_q.size() == 0) begin
        report_mismatch("result with no face pending");
      end else begin
        want = face_expect_q.pop_front();
        if (emitted_o !== want.emitted)
          report_mismatch($sformatf("emitted %b, want %b", emitted_o, want.emitted));
        if (out_first_o !== want.idx_first)
          report_mismatch($sformatf("out_first %0d, want %0d", out_first_o,
                                    want.idx_first));
        if (out_second_o !== want.idx_second)
          report_mismatch($sformatf("out_second %0d, want %0d", out_second_o,
                                    want.idx_second));
        if (out_third_o !== want.idx_third)
          report_mismatch($sformatf("out_third %0d, want %0d", out_third_o,
                                    want.idx_third));
        if (rejected_total_o !== want.reject_total)
          report_mismatch($sformatf("rejected_total %0d, want %0d", rejected_total_o,
                                    want.reject_total));
      end
    end
  end

  // cycles with neither an item transfer nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [63:0] wide;
    int          idle_plan [5];
    idle_plan = '{0, 55, 0, 18, 55};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_threshold('0);
    // unit triangle, a point on the line of its first edge, and a triangle on range corners
    queue_vertex(0, 0, 0, 0);
    queue_vertex(1, 1, 0, 0);
    queue_vertex(2, 0, 1, 0);
    queue_vertex(3, 2, 0, 0);
    queue_vertex(4095, -32768, -32768, -32768);
    queue_vertex(4094, 32767, -32768, 32767);
    queue_vertex(4093, 32767, 32767, -32768);
    queue_face(0, 1, 2, 0, 0, 1, 1'b0);
    queue_face(0, 1, 2, 0, 0, -1, 1'b0);
    queue_face(0, 1, 2, 1, 1, 0, 1'b0);
    queue_face(0, 1, 2, -32768, -32768, -32768, 1'b1);
    queue_face(0, 1, 2, 32767, 32767, 32767, 1'b0);
    queue_face(0, 0, 2, 0, 0, 1, 1'b0);
    queue_face(0, 1, 1, 0, 0, 1, 1'b0);
    queue_face(2, 1, 2, 0, 0, 1, 1'b0);
    queue_face(0, 1, 3, 0, 0, 1, 1'b0);
    // squared norm of these saturates
    queue_face(4095, 4094, 4093, 1, -1, 1, 1'b0);
    queue_face(4093, 4094, 4095, 1, -1, 1, 1'b0);

    // threshold equal to the unit triangle norm rejects it
    set_threshold(1);
    queue_face(0, 1, 2, 0, 0, 1, 1'b0);
    queue_face(4095, 4094, 4093, -7, 3, 100, 1'b0);

    set_threshold('1);
    queue_face(2, 0, 1, 5, 5, 5, 1'b0);
    queue_face(4094, 4095, 4093, 1, 2, 3, 1'b0);

    for (int ph = 0; ph < 5; ph++) begin
      wide = {$urandom, $urandom};
      case (ph)
        0: set_threshold('0);
        1: set_threshold(THR_W'($urandom_range(1 << 20, 1)));
        2: set_threshold(THR_W'(wide[39:0]));
        3: set_threshold(wide[THR_W-1:0]);
        default: set_threshold({1'b1, wide[THR_W-2:0]});
      endcase
      sender_idle_pct = idle_plan[ph];
      queue_mesh_batch(BATCH_ITEMS);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
